### rtl/rdc_pkg.sv
// rdc_pkg: shared types and constants for the radix digit converter.
// Holds the transfer payload structs and the sequencer state type.
// No dependencies.
`default_nettype none

package rdc_pkg;

   localparam int INT_WIDTH_DEF  = 31;
   localparam int FRAC_WIDTH_DEF = 32;
   localparam int FRAC_DIGITS_MAX = 32;
   localparam int RADIX_MIN = 2;
   localparam int RADIX_MAX = 16;
   localparam int RADIX_RESET = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 6;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAC_DIGITS = 2'd1;

   typedef struct packed {
      logic [30:0] integer_part;
      logic [31:0] fraction_part;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] digit;
      logic       in_fraction;
      logic       last;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT_INT,
      ST_EMIT_FRAC
   } state_type;

endpackage

`default_nettype wire

### rtl/radix_digit_converter.sv
// radix_digit_converter: integer and fraction digits of a value in radix 2..16.
// Depends on rdc_pkg for payload structs, register indexes and the state type.
`default_nettype none

// One input item yields its digits most significant first: the integer digits
// (a zero integer part gives the single digit 0), then frac_digits fraction
// digits, the item's final digit flagged by last. The block takes an item only when idle.
// Each integer digit comes from a full pass of the shared divider, which
// retires four quotient bits per cycle; the integer digits then leave at one
// per cycle from a small digit buffer while the output is not stalled, and
// each fraction digit comes from one multiplication by the radix. Radix
// values outside 2..16 saturate to the nearer bound, frac_digits above 32
// counts as 32, and writes to unused register indexes are dropped.
module radix_digit_converter #(
   parameter int INT_WIDTH  = rdc_pkg::INT_WIDTH_DEF,
   parameter int FRAC_WIDTH = rdc_pkg::FRAC_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire rdc_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output rdc_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                 csr_write_en,
   input  wire logic [rdc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [rdc_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import rdc_pkg::*;

   localparam int STEP_BITS = 4;
   localparam int DIV_CYC   = (INT_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int QW        = DIV_CYC * STEP_BITS;
   localparam int CW        = $clog2(DIV_CYC);
   localparam int BW        = $clog2(INT_WIDTH);
   localparam int NW        = $clog2(INT_WIDTH + 1);

   // configuration
   logic [4:0] radix_ff, radix_in;
   logic [5:0] frac_ff, frac_in;

   // sequencer and datapath
   state_type       state_ff, state_in;
   logic [QW-1:0]   quo_ff, quo_in;
   logic [3:0]      rem_ff, rem_in;
   logic [CW-1:0]   cyc_ff, cyc_in;
   logic [NW-1:0]   ni_ff, ni_in;
   logic [NW-1:0]   ei_ff, ei_in;
   logic [FRAC_WIDTH-1:0] frac_val_ff, frac_val_in;
   logic [4:0]      r_ff, r_in;
   logic [5:0]      nf_ff, nf_in;
   logic [5:0]      fc_ff, fc_in;
   logic [3:0]      buf_ff [INT_WIDTH];

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            accept;
   logic            out_free;
   logic            load;
   logic            buf_we;
   logic [4:0]      r_eff;
   logic [5:0]      nf_eff;
   logic [QW-1:0]   quo_step;
   logic [3:0]      rem_step;
   logic            div_done;
   logic [NW-1:0]   ei_m1;
   logic [FRAC_WIDTH+4:0] prod;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // configuration writes
   always_comb begin
      radix_in = radix_ff;
      frac_in  = frac_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RADIX:       radix_in = csr_wdata[4:0];
            CSR_FRAC_DIGITS: frac_in  = csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (radix_ff < 5'(RADIX_MIN)) begin
         r_eff = 5'(RADIX_MIN);
      end else if (radix_ff > 5'(RADIX_MAX)) begin
         r_eff = 5'(RADIX_MAX);
      end else begin
         r_eff = radix_ff;
      end
      nf_eff = (frac_ff > 6'(FRAC_DIGITS_MAX)) ? 6'(FRAC_DIGITS_MAX) : frac_ff;
   end

   // shared divider: four restoring steps per cycle on the top quotient bits
   always_comb begin
      logic [4:0] t;
      logic [3:0] r;
      logic [STEP_BITS-1:0] qb;
      r  = rem_ff;
      qb = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
         t = {r, quo_ff[QW-1-k]};
         if (t >= r_ff) begin
            t = t - r_ff;
            qb[STEP_BITS-1-k] = 1'b1;
         end
         r = t[3:0];
      end
      rem_step = r;
      quo_step = {quo_ff[QW-STEP_BITS-1:0], qb};
   end

   assign div_done = (cyc_ff == CW'(DIV_CYC - 1));
   assign ei_m1    = ei_ff - NW'(1);
   assign prod     = {5'd0, frac_val_ff} * {{FRAC_WIDTH{1'b0}}, r_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done && quo_step == '0) state_in = ST_EMIT_INT;
         end
         ST_EMIT_INT: begin
            if (out_free && ei_ff == NW'(1)) begin
               state_in = (nf_ff == '0) ? ST_IDLE : ST_EMIT_FRAC;
            end
         end
         ST_EMIT_FRAC: begin
            if (out_free && (fc_ff + 6'd1) == nf_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      cyc_in      = cyc_ff;
      ni_in       = ni_ff;
      ei_in       = ei_ff;
      frac_val_in = frac_val_ff;
      r_in        = r_ff;
      nf_in       = nf_ff;
      fc_in       = fc_ff;
      buf_we      = 1'b0;
      load        = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               quo_in      = QW'(req_payload.integer_part[INT_WIDTH-1:0]);
               frac_val_in = req_payload.fraction_part[FRAC_WIDTH-1:0];
               rem_in      = '0;
               cyc_in      = '0;
               ni_in       = '0;
               fc_in       = '0;
               r_in        = r_eff;
               nf_in       = nf_eff;
            end
         end
         ST_DIV: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cyc_in = cyc_ff + CW'(1);
            if (div_done) begin
               buf_we = 1'b1;
               ni_in  = ni_ff + NW'(1);
               cyc_in = '0;
               rem_in = '0;
               ei_in  = ni_ff + NW'(1);
            end
         end
         ST_EMIT_INT: begin
            if (out_free) begin
               load = 1'b1;
               rsp_payload_in.digit       = buf_ff[ei_m1[BW-1:0]];
               rsp_payload_in.in_fraction = 1'b0;
               rsp_payload_in.last        = (ei_ff == NW'(1)) && (nf_ff == '0);
               ei_in = ei_m1;
            end
         end
         ST_EMIT_FRAC: begin
            if (out_free) begin
               load = 1'b1;
               rsp_payload_in.digit       = prod[FRAC_WIDTH+3:FRAC_WIDTH];
               rsp_payload_in.in_fraction = 1'b1;
               rsp_payload_in.last        = ((fc_ff + 6'd1) == nf_ff);
               frac_val_in = prod[FRAC_WIDTH-1:0];
               fc_in       = fc_ff + 6'd1;
            end
         end
         default: ;
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radix_ff     <= 5'(RADIX_RESET);
         frac_ff      <= '0;
         cyc_ff       <= '0;
         ni_ff        <= '0;
         ei_ff        <= '0;
         fc_ff        <= '0;
         nf_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radix_ff     <= radix_in;
         frac_ff      <= frac_in;
         cyc_ff       <= cyc_in;
         ni_ff        <= ni_in;
         ei_ff        <= ei_in;
         fc_ff        <= fc_in;
         nf_ff        <= nf_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      frac_val_ff    <= frac_val_in;
      r_ff           <= r_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // digit buffer, filled least significant first
   always_ff @(posedge clock) begin
      if (buf_we) buf_ff[ni_ff[BW-1:0]] <= rem_step;
   end

   // a radix-2 expansion of the widest integer part still fits the buffer
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> ni_ff < NW'(INT_WIDTH))
      else $error("digit buffer overrun");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_INT |-> ei_ff != '0 && ei_ff <= ni_ff)
      else $error("integer digit index out of range");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_FRAC |-> fc_ff < nf_ff)
      else $error("fraction digit count overrun");

   assert property (@(posedge clock) disable iff (reset)
      load && rsp_payload_in.last |=> state_ff == ST_IDLE)
      else $error("last digit issued but sequencer still busy");

   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_DIV && ni_ff == '0)
      else $error("transfer accepted without starting division");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for radix_digit_converter, directed table then random values.
// Digits are predicted in-bench or typed into the table, and compared per transfer in order.
// Depends on rdc_pkg and the radix_digit_converter RTL.

module tb;
   import rdc_pkg::*;

   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 30;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_B = 2'd3;

   typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_type;

   // n_int of zero means the digits come from the predictor
   typedef struct {
      row_kind_type                kind;
      logic [CSR_INDEX_WIDTH-1:0]  index;
      logic [CSR_DATA_WIDTH-1:0]   value;
      logic [30:0]                 whole;
      logic [31:0]                 frac;
      int                          n_int;
      int                          n_frac;
      logic [63:0]                 nibbles;
   } stim_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   req_payload_type             req_payload;
   logic                        rsp_valid;
   logic                        rsp_stall;
   rsp_payload_type             rsp_payload;
   logic                        csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata;

   stim_row_type     stim_table [$];
   rsp_payload_type  pending_digits [$];
   logic [4:0]       cfg_radix;
   logic [5:0]       cfg_frac;
   int               items_sent;
   int               digits_seen;
   int               settings_written;
   int               mismatches;

   radix_digit_converter u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic bit calm_stretch();
      return items_sent >= 200 && items_sent < 260;
   endfunction

   // Digits of one value under the shadow radix and fraction length.
   function automatic void predict_digits(input logic [30:0] whole, input logic [31:0] frac);
      int unsigned     base;
      int unsigned     nfrac;
      logic [3:0]      int_digs [32];
      int              n;
      logic [31:0]     w;
      logic [31:0]     f;
      logic [63:0]     prod;
      rsp_payload_type d;
      base  = (cfg_radix < RADIX_MIN) ? RADIX_MIN :
              (cfg_radix > RADIX_MAX) ? RADIX_MAX : cfg_radix;
      nfrac = (cfg_frac > FRAC_DIGITS_MAX) ? FRAC_DIGITS_MAX : cfg_frac;
      w = {1'b0, whole};
      f = frac;
      n = 0;
      do begin
         int_digs[n] = 4'(w % base);
         n++;
         w = w / base;
      end while (w != 0);
      for (int i = n - 1; i >= 0; i--) begin
         d.digit       = int_digs[i];
         d.in_fraction = 1'b0;
         d.last        = (i == 0 && nfrac == 0);
         pending_digits.push_back(d);
      end
      for (int i = 0; i < nfrac; i++) begin
         prod          = {32'd0, f} * base;
         d.digit       = prod[35:32];
         d.in_fraction = 1'b1;
         d.last        = (i == nfrac - 1);
         f             = prod[31:0];
         pending_digits.push_back(d);
      end
   endfunction

   // Hand-written digits, most significant nibble first, right aligned.
   function automatic void push_typed_digits(input logic [63:0] nibbles, input int n_int,
                                             input int n_frac);
      rsp_payload_type d;
      int              total;
      total = n_int + n_frac;
      for (int k = 0; k < total; k++) begin
         d.digit       = nibbles[4*(total-1-k) +: 4];
         d.in_fraction = (k >= n_int);
         d.last        = (k == total - 1);
         pending_digits.push_back(d);
      end
   endfunction

   function automatic void add_write(input logic [CSR_INDEX_WIDTH-1:0] index,
                                     input logic [CSR_DATA_WIDTH-1:0] value);
      stim_row_type row;
      row = '{ROW_WRITE, index, value, '0, '0, 0, 0, '0};
      stim_table.push_back(row);
   endfunction

   function automatic void add_item(input logic [30:0] whole, input logic [31:0] frac,
                                    input int n_int, input int n_frac,
                                    input logic [63:0] nibbles);
      stim_row_type row;
      row = '{ROW_ITEM, '0, '0, whole, frac, n_int, n_frac, nibbles};
      stim_table.push_back(row);
   endfunction

   // Registers only change once the block has drained.
   task automatic program_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                              input logic [CSR_DATA_WIDTH-1:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_RADIX:       cfg_radix = val[4:0];
         CSR_FRAC_DIGITS: cfg_frac  = val;
         default: ;
      endcase
      settings_written++;
   endtask

   task automatic send_item(input logic [30:0] whole, input logic [31:0] frac,
                            input int n_int, input int n_frac, input logic [63:0] nibbles);
      req_payload_type p;
      p.integer_part  = whole;
      p.fraction_part = frac;
      @(negedge clock);
      while (!calm_stretch() && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      if (n_int > 0)
         push_typed_digits(nibbles, n_int, n_frac);
      else
         predict_digits(whole, frac);
      items_sent++;
   endtask

   function automatic void note_mismatch(input string field, input int want, input int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endfunction

   // Result side: one check per accepted transfer.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         digits_seen++;
         if (pending_digits.size() == 0) begin
            mismatches++;
            $display("%0t: digit transfer with nothing expected, expected none, got %0d",
                     $time, rsp_payload.digit);
         end else begin
            want = pending_digits.pop_front();
            if (rsp_payload.digit !== want.digit)
               note_mismatch("digit", want.digit, rsp_payload.digit);
            if (rsp_payload.in_fraction !== want.in_fraction)
               note_mismatch("in_fraction", want.in_fraction, rsp_payload.in_fraction);
            if (rsp_payload.last !== want.last)
               note_mismatch("last", want.last, rsp_payload.last);
         end
      end
   end

   // Receiver: random stalls, one long hold to back the block up, a calm stretch.
   initial begin
      int hold_left;
      bit held;
      rsp_stall = 1'b0;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && items_sent >= 100) begin
            held      = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm_stretch() && ($urandom_range(0, 99) < 7);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d digits still outstanding", pending_digits.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [30:0]               whole;
      logic [31:0]               frac;
      logic [CSR_DATA_WIDTH-1:0] rv;
      logic [CSR_DATA_WIDTH-1:0] fv;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      cfg_radix        = RADIX_RESET;
      cfg_frac         = '0;
      items_sent       = 0;
      digits_seen      = 0;
      settings_written = 0;
      mismatches       = 0;

      // reset values: radix 10, no fraction digits
      add_item(0, 32'h0, 1, 0, 64'h0);
      add_item(7, 32'hFFFF_FFFF, 1, 0, 64'h7);
      add_item(31'h7FFF_FFFF, 32'h0, 0, 0, '0);
      add_write(CSR_FRAC_DIGITS, 6'd4);
      add_item(0, 32'h8000_0000, 1, 4, 64'h0_5000);
      add_item(12, 32'h4000_0000, 2, 4, 64'h12_2500);
      add_write(CSR_RADIX, 6'd16);
      add_write(CSR_FRAC_DIGITS, 6'd8);
      add_item(31'h7FFF_FFFF, 32'hFFFF_FFFF, 8, 8, 64'h7FFF_FFFF_FFFF_FFFF);
      add_item(0, 32'h8000_0001, 1, 8, 64'h0_8000_0001);
      // out-of-range radix values saturate, and 34 is cut to its low five bits (2)
      add_write(CSR_RADIX, 6'd0);
      add_write(CSR_FRAC_DIGITS, 6'd0);
      add_item(5, 32'h0, 3, 0, 64'h101);
      add_write(CSR_RADIX, 6'd1);
      add_item(6, 32'h0, 3, 0, 64'h110);
      add_write(CSR_RADIX, 6'd17);
      add_item(255, 32'h0, 2, 0, 64'hFF);
      add_write(CSR_RADIX, 6'd31);
      add_item(256, 32'h0, 3, 0, 64'h100);
      add_write(CSR_RADIX, 6'd34);
      add_item(2, 32'h0, 2, 0, 64'h10);
      // fraction length clamps to 32; binary full-scale gives the longest burst
      add_write(CSR_FRAC_DIGITS, 6'd63);
      add_item(31'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0, '0);
      add_write(CSR_RADIX, 6'd3);
      add_write(CSR_FRAC_DIGITS, 6'd33);
      add_item(1000, 32'h5555_5555, 0, 0, '0);
      // spare indexes must leave radix 3, one fraction digit alone
      add_write(CSR_FRAC_DIGITS, 6'd1);
      add_write(CSR_SPARE_A, 6'd5);
      add_write(CSR_SPARE_B, 6'd63);
      add_item(9, 32'h8000_0000, 3, 1, 64'h1001);
      add_write(CSR_RADIX, 6'd7);
      add_write(CSR_FRAC_DIGITS, 6'd5);
      add_item(48, 32'h1234_5678, 0, 0, '0);
      add_item(49, 32'hFFFF_FFFF, 0, 0, '0);
      add_write(CSR_RADIX, 6'd15);
      add_item(31'h7FFF_FFFF, 32'h0000_0001, 0, 0, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_WRITE)
            program_reg(stim_table[i].index, stim_table[i].value);
         else
            send_item(stim_table[i].whole, stim_table[i].frac, stim_table[i].n_int,
                      stim_table[i].n_frac, stim_table[i].nibbles);
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin rv = 6'd16; fv = 6'd32; end
            1: begin rv = 6'd2;  fv = 6'd63; end
            2: begin rv = 6'd0;  fv = 6'd0;  end
            3: begin rv = 6'd31; fv = 6'd1;  end
            4: begin rv = 6'd10; fv = 6'd33; end
            5: begin rv = 6'd1;  fv = 6'd5;  end
            default: begin
               rv = 6'($urandom_range(0, 63));
               fv = 6'($urandom_range(0, 63));
            end
         endcase
         program_reg(CSR_RADIX, rv);
         program_reg(CSR_FRAC_DIGITS, fv);
         repeat (PHASE_ITEMS) begin
            case ($urandom_range(0, 9))
               0:       whole = '0;
               1:       whole = 31'h7FFF_FFFF;
               2, 3:    whole = 31'($urandom_range(0, 300));
               default: whole = 31'($urandom >> $urandom_range(1, 31));
            endcase
            case ($urandom_range(0, 7))
               0:       frac = '0;
               1:       frac = 32'hFFFF_FFFF;
               2:       frac = 32'h1 << $urandom_range(0, 31);
               default: frac = $urandom;
            endcase
            send_item(whole, frac, 0, 0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Converted %0d values into %0d checked digits across %0d register writes.",
               items_sent, digits_seen, settings_written);
      $display("Radix and fraction length swept to both limits, with a %0d-cycle output hold.",
               LONG_HOLD);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
rtl/rdc_pkg.sv
rtl/radix_digit_converter.sv
verif/tb.sv
